// ===== sv/tfc_pkg.sv =====
`default_nettype none

package tfc_pkg;

	// Frame limit and snapshot length width (the limit never exceeds 16 bits)
	localparam int unsigned MAX_FRAME_BYTES_DEF = 8192;
	localparam int unsigned LEN_W               = 16;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PORT_PRIMARY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PORT_ALTERNATE = 2'd1;

	localparam logic [15:0] PORT_PRIMARY_RST   = 16'd443;
	localparam logic [15:0] PORT_ALTERNATE_RST = 16'd8443;

	// Byte positions within the frame
	localparam int unsigned POS_ETHER_HI     = 12;
	localparam int unsigned POS_ETHER_LO     = 13;
	localparam int unsigned POS_IHL          = 14;
	localparam int unsigned POS_PROTO        = 23;
	localparam int unsigned POS_SRC_IP_FIRST = 26;
	localparam int unsigned POS_SRC_IP_LAST  = 29;
	localparam int unsigned POS_DST_IP_FIRST = 30;
	localparam int unsigned POS_DST_IP_LAST  = 33;

	localparam int unsigned ETH_HDR_BYTES  = 14;
	localparam int unsigned IP_PROTO_NEED  = 24;
	localparam int unsigned TCP_PORT_BYTES = 4;
	localparam int unsigned TCP_OFF_POS    = 12;
	localparam int unsigned TCP_OFF_NEED   = 13;
	localparam int unsigned MIN_HDR_BYTES  = 20;
	localparam int unsigned TLS_HDR_BYTES  = 5;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  TLS_TYPE_LOW   = 8'd20;
	localparam logic [7:0]  TLS_TYPE_HIGH  = 8'd23;

	// Verdict codes
	localparam logic [2:0] VERDICT_TLS       = 3'd0;
	localparam logic [2:0] VERDICT_NOT_IPV4  = 3'd1;
	localparam logic [2:0] VERDICT_NOT_TCP   = 3'd2;
	localparam logic [2:0] VERDICT_NO_PORT   = 3'd3;
	localparam logic [2:0] VERDICT_MALFORMED = 3'd4;
	localparam logic [2:0] VERDICT_SHORT     = 3'd5;
	localparam logic [2:0] VERDICT_NOT_TLS   = 3'd6;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} frame_in_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [31:0] src_address;
		logic [31:0] dst_address;
		logic [15:0] src_port_out;
		logic [15:0] dst_port_out;
		logic [13:0] payload_length;
		logic [7:0]  content_type;
		logic [15:0] record_version;
		logic [15:0] record_length;
	} verdict_out_t;

	// Header fields of one finished frame, handed from capture to judge
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [15:0]      ether_kind;
		logic [5:0]       ip_hdr_bytes;
		logic [7:0]       ip_protocol;
		logic [31:0]      src_ip;
		logic [31:0]      dst_ip;
		logic [15:0]      tcp_src;
		logic [15:0]      tcp_dst;
		logic [5:0]       tcp_hdr_bytes;
		logic [39:0]      tls_hdr;
	} snap_t;

endpackage

`default_nettype wire

// ===== sv/tfc_capture.sv =====
`default_nettype none

module tfc_capture #(
	parameter int unsigned MAX_FRAME_BYTES = tfc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire tfc_pkg::frame_in_t in_data,
	output logic                   snap_valid,
	output tfc_pkg::snap_t         snap,
	input  wire logic              take
);
	import tfc_pkg::*;

	localparam int unsigned OFF_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_FRAME_BYTES);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             consume;

	logic             snap_valid_s2;
	snap_t            snap_s2;

	logic [OFF_W-1:0] offset_q, offset_nx;
	logic [15:0]      ether_q, ether_nx;
	logic [5:0]       ihl_q, ihl_nx;
	logic [7:0]       proto_q, proto_nx;
	logic [31:0]      src_ip_q, src_ip_nx;
	logic [31:0]      dst_ip_q, dst_ip_nx;
	logic [15:0]      src_port_q, src_port_nx;
	logic [15:0]      dst_port_q, dst_port_nx;
	logic [5:0]       tcp_hdr_q, tcp_hdr_nx;
	logic [39:0]      tls_q, tls_nx;

	logic [OFF_W-1:0] tcp_base;
	logic [OFF_W-1:0] tcp_pos;
	logic [OFF_W-1:0] pay_pos;

	// A final byte needs room in the snapshot stage; others only update state
	assign consume  = valid_s1 && (!last_s1 || !snap_valid_s2 || take);
	assign in_stall = valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_data.frame_byte;
			last_s1 <= in_data.frame_last;
		end
	end

	always_comb begin
		offset_nx   = offset_q;
		ether_nx    = ether_q;
		ihl_nx      = ihl_q;
		proto_nx    = proto_q;
		src_ip_nx   = src_ip_q;
		dst_ip_nx   = dst_ip_q;
		src_port_nx = src_port_q;
		dst_port_nx = dst_port_q;
		tcp_hdr_nx  = tcp_hdr_q;
		tls_nx      = tls_q;

		tcp_base = OFF_W'(ETH_HDR_BYTES) + OFF_W'(ihl_q);
		tcp_pos  = offset_q - tcp_base;
		pay_pos  = tcp_pos - OFF_W'(tcp_hdr_q);

		// Saturate at the frame limit and ignore the bytes beyond it
		if (offset_q < OFF_MAX) begin
			offset_nx = offset_q + OFF_W'(1);

			if (offset_q == OFF_W'(POS_ETHER_HI) || offset_q == OFF_W'(POS_ETHER_LO)) begin
				ether_nx = {ether_q[7:0], byte_s1};
			end else if (offset_q == OFF_W'(POS_IHL)) begin
				ihl_nx = {byte_s1[3:0], 2'b00};
			end else if (offset_q == OFF_W'(POS_PROTO)) begin
				proto_nx = byte_s1;
			end else if (offset_q >= OFF_W'(POS_SRC_IP_FIRST) &&
			             offset_q <= OFF_W'(POS_SRC_IP_LAST)) begin
				src_ip_nx = {src_ip_q[23:0], byte_s1};
			end else if (offset_q >= OFF_W'(POS_DST_IP_FIRST) &&
			             offset_q <= OFF_W'(POS_DST_IP_LAST)) begin
				dst_ip_nx = {dst_ip_q[23:0], byte_s1};
			end

			// TCP fields only behind a sound IP header
			if (ihl_q >= 6'(MIN_HDR_BYTES) && offset_q >= tcp_base) begin
				if (tcp_pos < OFF_W'(2)) begin
					src_port_nx = {src_port_q[7:0], byte_s1};
				end else if (tcp_pos < OFF_W'(TCP_PORT_BYTES)) begin
					dst_port_nx = {dst_port_q[7:0], byte_s1};
				end
				if (tcp_hdr_q >= 6'(MIN_HDR_BYTES) && tcp_pos >= OFF_W'(tcp_hdr_q) &&
				    pay_pos < OFF_W'(TLS_HDR_BYTES)) begin
					case (pay_pos[2:0])
						3'd0: tls_nx[39:32] = byte_s1;
						3'd1: tls_nx[31:24] = byte_s1;
						3'd2: tls_nx[23:16] = byte_s1;
						3'd3: tls_nx[15:8]  = byte_s1;
						default: tls_nx[7:0] = byte_s1;
					endcase
				end
				if (tcp_pos == OFF_W'(TCP_OFF_POS)) begin
					tcp_hdr_nx = {byte_s1[7:4], 2'b00};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			ether_q    <= '0;
			ihl_q      <= '0;
			proto_q    <= '0;
			src_ip_q   <= '0;
			dst_ip_q   <= '0;
			src_port_q <= '0;
			dst_port_q <= '0;
			tcp_hdr_q  <= '0;
			tls_q      <= '0;
		end else if (consume) begin
			if (last_s1) begin
				// Clear for the next frame
				offset_q   <= '0;
				ether_q    <= '0;
				ihl_q      <= '0;
				proto_q    <= '0;
				src_ip_q   <= '0;
				dst_ip_q   <= '0;
				src_port_q <= '0;
				dst_port_q <= '0;
				tcp_hdr_q  <= '0;
				tls_q      <= '0;
			end else begin
				offset_q   <= offset_nx;
				ether_q    <= ether_nx;
				ihl_q      <= ihl_nx;
				proto_q    <= proto_nx;
				src_ip_q   <= src_ip_nx;
				dst_ip_q   <= dst_ip_nx;
				src_port_q <= src_port_nx;
				dst_port_q <= dst_port_nx;
				tcp_hdr_q  <= tcp_hdr_nx;
				tls_q      <= tls_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (consume && last_s1) begin
			snap_valid_s2 <= 1'b1;
		end else if (take) begin
			snap_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			snap_s2.len           <= LEN_W'(offset_nx);
			snap_s2.ether_kind    <= ether_nx;
			snap_s2.ip_hdr_bytes  <= ihl_nx;
			snap_s2.ip_protocol   <= proto_nx;
			snap_s2.src_ip        <= src_ip_nx;
			snap_s2.dst_ip        <= dst_ip_nx;
			snap_s2.tcp_src       <= src_port_nx;
			snap_s2.tcp_dst       <= dst_port_nx;
			snap_s2.tcp_hdr_bytes <= tcp_hdr_nx;
			snap_s2.tls_hdr       <= tls_nx;
		end
	end

	assign snap_valid = snap_valid_s2;
	assign snap       = snap_s2;

	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= OFF_MAX)
		else $error("byte offset beyond frame limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last_s1 |=> offset_q == '0 && tls_q == '0 && ihl_q == '0)
		else $error("frame state not cleared after final byte");

	a_snap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid_s2 && !take |=> snap_valid_s2 && $stable(snap_s2))
		else $error("snapshot changed while waiting");

endmodule

`default_nettype wire

// ===== sv/tfc_judge.sv =====
`default_nettype none

module tfc_judge (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 snap_valid,
	input  wire tfc_pkg::snap_t       snap,
	output logic                      take,
	input  wire logic [15:0]          port_primary,
	input  wire logic [15:0]          port_alternate,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output tfc_pkg::verdict_out_t     out_data
);
	import tfc_pkg::*;

	logic             res_valid_s3;
	verdict_out_t     res_s3;
	verdict_out_t     res;

	logic [LEN_W-1:0] tcp_start;
	logic [LEN_W-1:0] hdr_total;
	logic             port_hit;
	logic             hdrs_ok;
	logic [7:0]       rec_type;

	assign take = !res_valid_s3 || !out_stall;

	always_comb begin
		tcp_start = LEN_W'(ETH_HDR_BYTES) + LEN_W'(snap.ip_hdr_bytes);
		hdr_total = tcp_start + LEN_W'(snap.tcp_hdr_bytes);
		rec_type  = snap.tls_hdr[39:32];
		port_hit  = snap.tcp_src == port_primary   || snap.tcp_dst == port_primary ||
		            snap.tcp_src == port_alternate || snap.tcp_dst == port_alternate;
		hdrs_ok   = snap.ip_hdr_bytes >= 6'(MIN_HDR_BYTES) &&
		            snap.tcp_hdr_bytes >= 6'(MIN_HDR_BYTES);

		// Checks in priority order; a frame ending early is short at that check
		if (snap.len < LEN_W'(ETH_HDR_BYTES)) begin
			res.verdict = VERDICT_SHORT;
		end else if (snap.ether_kind != ETHERTYPE_IPV4) begin
			res.verdict = VERDICT_NOT_IPV4;
		end else if (snap.len < LEN_W'(IP_PROTO_NEED)) begin
			res.verdict = VERDICT_SHORT;
		end else if (snap.ip_protocol != PROTO_TCP) begin
			res.verdict = VERDICT_NOT_TCP;
		end else if (snap.ip_hdr_bytes < 6'(MIN_HDR_BYTES)) begin
			res.verdict = VERDICT_MALFORMED;
		end else if (snap.len < tcp_start + LEN_W'(TCP_PORT_BYTES)) begin
			res.verdict = VERDICT_SHORT;
		end else if (!port_hit) begin
			res.verdict = VERDICT_NO_PORT;
		end else if (snap.len < tcp_start + LEN_W'(TCP_OFF_NEED)) begin
			res.verdict = VERDICT_SHORT;
		end else if (snap.tcp_hdr_bytes < 6'(MIN_HDR_BYTES)) begin
			res.verdict = VERDICT_MALFORMED;
		end else if (snap.len < hdr_total + LEN_W'(TLS_HDR_BYTES)) begin
			res.verdict = VERDICT_SHORT;
		end else if (rec_type < TLS_TYPE_LOW || rec_type > TLS_TYPE_HIGH) begin
			res.verdict = VERDICT_NOT_TLS;
		end else begin
			res.verdict = VERDICT_TLS;
		end

		res.src_address    = snap.src_ip;
		res.dst_address    = snap.dst_ip;
		res.src_port_out   = snap.tcp_src;
		res.dst_port_out   = snap.tcp_dst;
		res.payload_length = (hdrs_ok && snap.len > hdr_total) ?
		                     14'(snap.len - hdr_total) : '0;
		res.content_type   = rec_type;
		res.record_version = snap.tls_hdr[31:16];
		res.record_length  = snap.tls_hdr[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s3 <= 1'b0;
		end else if (take) begin
			res_valid_s3 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && snap_valid) begin
			res_s3 <= res;
		end
	end

	assign out_valid = res_valid_s3;
	assign out_data  = res_s3;

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		take && snap_valid |=> res_valid_s3)
		else $error("snapshot taken but no result registered");

	a_tls_type: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s3 && res_s3.verdict == VERDICT_TLS |->
		res_s3.content_type >= TLS_TYPE_LOW && res_s3.content_type <= TLS_TYPE_HIGH)
		else $error("TLS verdict with record type out of range");

	a_tls_headers: assert property (@(posedge clk) disable iff (!arst_n)
		take && snap_valid && res.verdict == VERDICT_TLS |->
		hdrs_ok && snap.ether_kind == ETHERTYPE_IPV4 && port_hit)
		else $error("TLS verdict without sound headers");

endmodule

`default_nettype wire

// ===== sv/tls_frame_classifier.sv =====
// A verdict reaches out_valid after the frame's final byte is accepted, through the input
// register, the header snapshot register and the result register.
// Throughput: one byte per cycle, frames back to back; the input stalls only while a
// finished verdict waits in both the snapshot and the result register.
// Reset: ports return to 443 and 8443 and all frame state clears; no clearing pass.
`default_nettype none

module tls_frame_classifier #(
	parameter int unsigned MAX_FRAME_BYTES = tfc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire tfc_pkg::frame_in_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output tfc_pkg::verdict_out_t                  out_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [15:0]                       cfg_data
);
	import tfc_pkg::*;

	logic [15:0] port_primary_q;
	logic [15:0] port_alternate_q;
	logic        snap_valid;
	snap_t       snap;
	logic        take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_primary_q   <= PORT_PRIMARY_RST;
			port_alternate_q <= PORT_ALTERNATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PORT_PRIMARY:   port_primary_q   <= cfg_data;
				REG_PORT_ALTERNATE: port_alternate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tfc_capture #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.snap_valid(snap_valid),
		.snap      (snap),
		.take      (take)
	);

	tfc_judge u_judge (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid    (snap_valid),
		.snap          (snap),
		.take          (take),
		.port_primary  (port_primary_q),
		.port_alternate(port_alternate_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data)
	);

endmodule

`default_nettype wire

// ===== dv/tb_tls_frame_classifier.sv =====
`default_nettype none

module tb_tls_frame_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	import tfc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef logic [7:0] octets_t [$];

	typedef struct {
		logic [15:0] etype;
		logic [7:0]  proto;
		int unsigned ihl;
		int unsigned doff;
		logic [15:0] sport;
		logic [15:0] dport;
		int unsigned paylen;
		logic [7:0]  ptype;
		int unsigned cut;
	} frame_plan_t;

	class verdict_scoreboard;
		logic [15:0] port_a;
		logic [15:0] port_b;
		int unsigned offset;
		int unsigned ip_hdr;
		int unsigned tcp_hdr;
		logic [15:0] ether_kind;
		logic [7:0]  ip_proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] tcp_src;
		logic [15:0] tcp_dst;
		logic [39:0] tls_hdr;
		verdict_out_t verdicts_due[$];
		int unsigned errors;

		function new();
			port_a = PORT_PRIMARY_RST;
			port_b = PORT_ALTERNATE_RST;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			offset = 0;
			ip_hdr = 0;
			tcp_hdr = 0;
			ether_kind = '0;
			ip_proto = '0;
			src_ip = '0;
			dst_ip = '0;
			tcp_src = '0;
			tcp_dst = '0;
			tls_hdr = '0;
		endfunction

		function void set_port(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			if (idx == REG_PORT_PRIMARY)
				port_a = val;
			else if (idx == REG_PORT_ALTERNATE)
				port_b = val;
		endfunction

		function int unsigned pending();
			return verdicts_due.size();
		endfunction

		function void note_byte(frame_in_t item);
			logic [7:0] b;
			int unsigned t;
			int unsigned p;
			int unsigned len;
			int unsigned tcp_start;
			verdict_out_t want;
			b = item.frame_byte;
			if (offset < MAX_FRAME_BYTES_DEF) begin
				if (offset == POS_ETHER_HI || offset == POS_ETHER_LO)
					ether_kind = {ether_kind[7:0], b};
				else if (offset == POS_IHL)
					ip_hdr = 4 * b[3:0];
				else if (offset == POS_PROTO)
					ip_proto = b;
				else if (offset >= POS_SRC_IP_FIRST && offset <= POS_SRC_IP_LAST)
					src_ip = {src_ip[23:0], b};
				else if (offset >= POS_DST_IP_FIRST && offset <= POS_DST_IP_LAST)
					dst_ip = {dst_ip[23:0], b};
				// TCP fields only behind a sane IP header, payload only behind a sane TCP one
				if (ip_hdr >= MIN_HDR_BYTES && offset >= ETH_HDR_BYTES + ip_hdr) begin
					t = offset - ETH_HDR_BYTES - ip_hdr;
					if (t < 2)
						tcp_src = {tcp_src[7:0], b};
					else if (t < TCP_PORT_BYTES)
						tcp_dst = {tcp_dst[7:0], b};
					if (tcp_hdr >= MIN_HDR_BYTES && t >= tcp_hdr) begin
						p = t - tcp_hdr;
						if (p < TLS_HDR_BYTES)
							tls_hdr[(4 - p) * 8 +: 8] = b;
					end
					if (t == TCP_OFF_POS)
						tcp_hdr = 4 * b[7:4];
				end
				offset++;
			end
			if (item.frame_last) begin
				len = offset;
				tcp_start = ETH_HDR_BYTES + ip_hdr;
				if (len < ETH_HDR_BYTES)
					want.verdict = VERDICT_SHORT;
				else if (ether_kind != ETHERTYPE_IPV4)
					want.verdict = VERDICT_NOT_IPV4;
				else if (len < IP_PROTO_NEED)
					want.verdict = VERDICT_SHORT;
				else if (ip_proto != PROTO_TCP)
					want.verdict = VERDICT_NOT_TCP;
				else if (ip_hdr < MIN_HDR_BYTES)
					want.verdict = VERDICT_MALFORMED;
				else if (len < tcp_start + TCP_PORT_BYTES)
					want.verdict = VERDICT_SHORT;
				else if (tcp_src != port_a && tcp_dst != port_a &&
						tcp_src != port_b && tcp_dst != port_b)
					want.verdict = VERDICT_NO_PORT;
				else if (len < tcp_start + TCP_OFF_NEED)
					want.verdict = VERDICT_SHORT;
				else if (tcp_hdr < MIN_HDR_BYTES)
					want.verdict = VERDICT_MALFORMED;
				else if (len < tcp_start + tcp_hdr + TLS_HDR_BYTES)
					want.verdict = VERDICT_SHORT;
				else if (tls_hdr[39:32] < TLS_TYPE_LOW || tls_hdr[39:32] > TLS_TYPE_HIGH)
					want.verdict = VERDICT_NOT_TLS;
				else
					want.verdict = VERDICT_TLS;
				want.payload_length = '0;
				if (ip_hdr >= MIN_HDR_BYTES && tcp_hdr >= MIN_HDR_BYTES &&
						len > tcp_start + tcp_hdr)
					want.payload_length = 14'(len - tcp_start - tcp_hdr);
				want.src_address = src_ip;
				want.dst_address = dst_ip;
				want.src_port_out = tcp_src;
				want.dst_port_out = tcp_dst;
				want.content_type = tls_hdr[39:32];
				want.record_version = tls_hdr[31:16];
				want.record_length = tls_hdr[15:0];
				verdicts_due.push_back(want);
				clear_frame();
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t ns %s: expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_verdict(verdict_out_t got);
			verdict_out_t want;
			if (verdicts_due.size() == 0) begin
				errors++;
				$display("%0t ns verdict: expected none, actual %h", $time, got);
			end else begin
				want = verdicts_due.pop_front();
				compare_field("verdict", want.verdict, got.verdict);
				compare_field("src_address", want.src_address, got.src_address);
				compare_field("dst_address", want.dst_address, got.dst_address);
				compare_field("src_port_out", want.src_port_out, got.src_port_out);
				compare_field("dst_port_out", want.dst_port_out, got.dst_port_out);
				compare_field("payload_length", want.payload_length, got.payload_length);
				compare_field("content_type", want.content_type, got.content_type);
				compare_field("record_version", want.record_version, got.record_version);
				compare_field("record_length", want.record_length, got.record_length);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	frame_in_t in_data;
	logic out_valid;
	logic out_stall;
	verdict_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;

	verdict_scoreboard sb;
	bit quiet = 1'b0;
	int unsigned bytes_pushed = 0;

	tls_frame_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_verdict(out_data);
	end

	// Receiver back-pressure: free stretches of varying length, then a stall burst unless quiet is set
	initial begin
		out_stall = 1'b0;
		forever begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(40, 200)) @(negedge clk);
			else
				repeat ($urandom_range(1, 20)) @(negedge clk);
			if (!quiet) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic hold_input(int unsigned cycles);
		in_valid = 1'b0;
		in_data = frame_in_t'($urandom);
		repeat (cycles) @(negedge clk);
	endtask

	task automatic push_byte(logic [7:0] b, logic last);
		frame_in_t item;
		item.frame_byte = b;
		item.frame_last = last;
		in_valid = 1'b1;
		in_data = item;
		do @(posedge clk); while (in_stall);
		sb.note_byte(item);
		bytes_pushed++;
		@(negedge clk);
	endtask

	// Hold the sender until every verdict is back, then let the pipeline settle
	task automatic await_verdicts();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_port(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_port(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [15:0] other_port();
		logic [15:0] v;
		do v = 16'($urandom); while (v == sb.port_a || v == sb.port_b);
		return v;
	endfunction

	function automatic frame_plan_t good_plan();
		frame_plan_t p;
		p.etype = ETHERTYPE_IPV4;
		p.proto = PROTO_TCP;
		p.ihl = 5;
		p.doff = 5;
		p.sport = sb.port_a;
		p.dport = other_port();
		p.paylen = $urandom_range(5, 8);
		p.ptype = 8'($urandom_range(TLS_TYPE_LOW, TLS_TYPE_HIGH));
		p.cut = 0;
		return p;
	endfunction

	function automatic int unsigned rand_words();
		int unsigned r;
		r = $urandom_range(0, 11);
		if (r == 0)
			return $urandom_range(0, 4);
		else if (r <= 6)
			return 5;
		else
			return $urandom_range(6, 15);
	endfunction

	function automatic logic [15:0] rand_port();
		case ($urandom_range(0, 3))
			0: return sb.port_a;
			1: return sb.port_b;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic frame_plan_t rand_plan();
		frame_plan_t p;
		p.etype = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETHERTYPE_IPV4;
		p.proto = ($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_TCP;
		p.ihl = rand_words();
		p.doff = rand_words();
		p.sport = rand_port();
		p.dport = rand_port();
		case ($urandom_range(0, 7))
			0, 1: p.paylen = $urandom_range(0, 4);
			7: p.paylen = $urandom_range(41, 300);
			default: p.paylen = $urandom_range(5, 40);
		endcase
		p.ptype = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
			8'($urandom_range(TLS_TYPE_LOW, TLS_TYPE_HIGH));
		p.cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 80) : 0;
		return p;
	endfunction

	task automatic send_plan(frame_plan_t p);
		octets_t f;
		int unsigned ip_bytes;
		int unsigned tcp_bytes;
		bit calm;
		ip_bytes = 4 * ((p.ihl < 5) ? 5 : p.ihl);
		tcp_bytes = 4 * ((p.doff < 5) ? 5 : p.doff);
		for (int i = 0; i < 12; i++)
			f.push_back(8'($urandom));
		f.push_back(p.etype[15:8]);
		f.push_back(p.etype[7:0]);
		f.push_back({4'($urandom), p.ihl[3:0]});
		for (int i = 1; i < ip_bytes; i++)
			f.push_back((i == POS_PROTO - ETH_HDR_BYTES) ? p.proto : 8'($urandom));
		for (int i = 0; i < tcp_bytes; i++) begin
			case (i)
				0: f.push_back(p.sport[15:8]);
				1: f.push_back(p.sport[7:0]);
				2: f.push_back(p.dport[15:8]);
				3: f.push_back(p.dport[7:0]);
				TCP_OFF_POS: f.push_back({p.doff[3:0], 4'($urandom)});
				default: f.push_back(8'($urandom));
			endcase
		end
		if (p.paylen > 0)
			f.push_back(p.ptype);
		for (int i = 1; i < p.paylen; i++)
			f.push_back(8'($urandom));
		if (p.cut != 0)
			while (f.size() > p.cut) void'(f.pop_back());
		calm = quiet || ($urandom_range(0, 3) == 0);
		foreach (f[i]) begin
			if (!calm && $urandom_range(0, 7) == 0)
				hold_input($urandom_range(1, 11));
			push_byte(f[i], i == f.size() - 1);
		end
	endtask

	initial begin
		frame_plan_t p;
		int unsigned mark;
		int unsigned frames;
		logic [15:0] shared;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_PORT_PRIMARY;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed frames on the reset ports
		send_plan(good_plan());
		p = good_plan(); p.sport = other_port(); p.dport = sb.port_b;
		p.ptype = TLS_TYPE_HIGH; p.paylen = TLS_HDR_BYTES; send_plan(p);
		p = good_plan(); p.ihl = 15; p.doff = 15; p.ptype = TLS_TYPE_LOW; send_plan(p);
		p = good_plan(); p.ptype = TLS_TYPE_LOW - 8'd1; send_plan(p);
		p = good_plan(); p.ptype = TLS_TYPE_HIGH + 8'd1; send_plan(p);
		p = good_plan(); p.ptype = 8'h00; send_plan(p);
		p = good_plan(); p.ptype = 8'hff; send_plan(p);
		p = good_plan(); p.cut = 1; send_plan(p);
		p = good_plan(); p.cut = ETH_HDR_BYTES - 1; send_plan(p);
		p = good_plan(); p.cut = ETH_HDR_BYTES; send_plan(p);
		p = good_plan(); p.cut = IP_PROTO_NEED - 1; send_plan(p);
		p = good_plan(); p.etype = 16'h86dd; send_plan(p);
		p = good_plan(); p.proto = 8'd17; send_plan(p);
		p = good_plan(); p.ihl = 0; send_plan(p);
		p = good_plan(); p.ihl = 4; send_plan(p);
		p = good_plan(); p.sport = other_port(); send_plan(p);
		p = good_plan(); p.cut = ETH_HDR_BYTES + MIN_HDR_BYTES + TCP_PORT_BYTES - 1; send_plan(p);
		p = good_plan(); p.cut = ETH_HDR_BYTES + MIN_HDR_BYTES + TCP_OFF_NEED - 1; send_plan(p);
		p = good_plan(); p.doff = 0; send_plan(p);
		p = good_plan(); p.doff = 4; send_plan(p);
		p = good_plan(); p.paylen = TLS_HDR_BYTES - 1; send_plan(p);
		p = good_plan(); p.paylen = 0; send_plan(p);

		for (int k = 0; k < 4; k++) begin
			await_verdicts();
			case (k)
				0: begin
					write_port(REG_PORT_PRIMARY, 16'h0000);
					write_port(REG_PORT_ALTERNATE, 16'hffff);
				end
				1: begin
					write_port(REG_PORT_PRIMARY, 16'hffff);
					write_port(REG_PORT_ALTERNATE, 16'h0000);
				end
				2: begin
					write_port(REG_PORT_PRIMARY, 16'($urandom));
					write_port(REG_PORT_ALTERNATE, 16'($urandom));
					// spare indexes must leave both ports alone
					write_port(REG_SPARE_2, 16'($urandom));
					write_port(REG_SPARE_3, 16'($urandom));
				end
				default: begin
					shared = 16'($urandom);
					write_port(REG_PORT_PRIMARY, shared);
					write_port(REG_PORT_ALTERNATE, shared);
				end
			endcase
			quiet = (k == 3);
			mark = bytes_pushed;
			frames = 0;
			while (frames < 2 || bytes_pushed - mark < 100) begin
				if ($urandom_range(0, 15) == 0)
					await_verdicts();
				send_plan(rand_plan());
				frames++;
			end
		end

		await_verdicts();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
